// File: hw/rtl/mck_pkg.sv
// Shared types, constants and the letter table of the Morse code keyer.
package mck_pkg;

  localparam int unsigned QUEUE_DEPTH = 128;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] DOT_RESET  = 16'd400;
  localparam logic [7:0]  CHAR_A     = 8'h61;
  localparam logic [7:0]  CHAR_Z     = 8'h7a;
  localparam logic [7:0]  CHAR_SPACE = 8'h20;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic push_ok;
    cnt_t occ;
    cnt_t occ_next;
  } q_stat_t;

  typedef struct packed {
    logic       speaker;
    logic [3:0] bar_levels;
    logic [7:0] queue_count;
    logic       dropped;
    logic       busy_res;
  } result_t;

  // high nibble: element count, low nibble: dash bits, first element in bit 0
  function automatic logic [7:0] letter_code(input logic [4:0] idx);
    logic [7:0] code;
    case (idx)
      5'd0:    code = 8'h22;
      5'd1:    code = 8'h41;
      5'd2:    code = 8'h45;
      5'd3:    code = 8'h31;
      5'd4:    code = 8'h10;
      5'd5:    code = 8'h44;
      5'd6:    code = 8'h33;
      5'd7:    code = 8'h40;
      5'd8:    code = 8'h20;
      5'd9:    code = 8'h4E;
      5'd10:   code = 8'h35;
      5'd11:   code = 8'h42;
      5'd12:   code = 8'h23;
      5'd13:   code = 8'h21;
      5'd14:   code = 8'h37;
      5'd15:   code = 8'h46;
      5'd16:   code = 8'h4B;
      5'd17:   code = 8'h32;
      5'd18:   code = 8'h30;
      5'd19:   code = 8'h11;
      5'd20:   code = 8'h34;
      5'd21:   code = 8'h48;
      5'd22:   code = 8'h36;
      5'd23:   code = 8'h49;
      5'd24:   code = 8'h4D;
      5'd25:   code = 8'h43;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  function automatic ptr_t next_ptr(input ptr_t p);
    return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

endpackage

// File: hw/rtl/mck_in_if.sv
// Request channel carrying one tick and an optional typed character.
interface mck_in_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] char_code;

  modport source (output valid, output char_valid, output char_code, input ready);
  modport sink (input valid, input char_valid, input char_code, output ready);
endinterface

// File: hw/rtl/mck_out_if.sv
// Result channel carrying the keyer outputs after each tick.
interface mck_out_if;
  logic       valid;
  logic       ready;
  logic       speaker;
  logic [3:0] bar_levels;
  logic [7:0] queue_count;
  logic       dropped;
  logic       busy_res;

  modport source (output valid, output speaker, output bar_levels, output queue_count,
                  output dropped, output busy_res, input ready);
  modport sink (input valid, input speaker, input bar_levels, input queue_count,
                input dropped, input busy_res, output ready);
endinterface

// File: hw/rtl/mck_cfg_if.sv
// Configuration write channel for the dot length register.
interface mck_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] dot_ticks;

  modport source (output valid, output dot_ticks, input ready);
  modport sink (input valid, input dot_ticks, output ready);
endinterface

// File: hw/rtl/mck_queue.sv
// Character FIFO in a synchronous RAM with a prefetched head and write forwarding.
module mck_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mck_pkg::q_ctrl_t ctrl_i,
  input  logic [7:0]       push_data_i,
  output mck_pkg::q_stat_t stat_o,
  output logic [7:0]       head_o
);
  import mck_pkg::*;

  logic [7:0] mem [QUEUE_DEPTH];
  logic [7:0] rdata_q;
  ptr_t       wr_q, wr_d, rd_q, rd_d;
  cnt_t       occ_q, occ_d;
  logic       push_ok;

  assign push_ok = ctrl_i.push && (occ_q != cnt_t'(QUEUE_DEPTH));
  assign wr_d    = push_ok ? next_ptr(wr_q) : wr_q;
  assign rd_d    = ctrl_i.pop ? next_ptr(rd_q) : rd_q;

  always_comb begin
    occ_d = occ_q;
    case ({push_ok, ctrl_i.pop})
      2'b10:   occ_d = cnt_t'(occ_q + 1'b1);
      2'b01:   occ_d = cnt_t'(occ_q - 1'b1);
      default: occ_d = occ_q;
    endcase
  end

  // empty queue: the character pushed this tick is the head
  assign head_o = (occ_q == '0) ? push_data_i : rdata_q;

  assign stat_o.push_ok  = push_ok;
  assign stat_o.occ      = occ_q;
  assign stat_o.occ_next = occ_d;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[wr_q] <= push_data_i;
    end
    if (push_ok && (wr_q == rd_d)) begin
      rdata_q <= push_data_i;
    end else begin
      rdata_q <= mem[rd_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      occ_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      occ_q <= occ_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> (occ_q != '0) || push_ok)
    else $error("pop from empty queue");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= cnt_t'(QUEUE_DEPTH))
    else $error("queue occupancy overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> (wr_q == rd_q))
    else $error("pointers disagree on empty queue");
`endif
endmodule

// File: hw/rtl/morse_code_keyer.sv
// Morse code keyer top level: character queue, element player, result buffer.
// Each accepted tick's result is registered in main_q, or first in skid_q while main_q is held, to drive out_o.
// Throughput: one tick per cycle while in_i is ready; the queue head is prefetched from the RAM.
// Results wait in a two-entry buffer; in_i stalls only when both entries are full.
// Reset: asynchronous, clears pointers, player state and buffers; dot_ticks returns to 400.
module morse_code_keyer (
  input  logic      clk_i,
  input  logic      rst_ni,
  mck_in_if.sink    in_i,
  mck_cfg_if.sink   cfg_i,
  mck_out_if.source out_o
);
  import mck_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TONE,
    PH_GAP,
    PH_SPACE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [18:0] timer_q, timer_d;
  logic [3:0]  pat_q, pat_d;
  logic [2:0]  left_q, left_d;
  logic        tone_q, tone_d;
  logic [15:0] dot_q;

  logic [15:0] dot_len;
  logic [18:0] len1, len3, len7;
  logic        in_fire, out_fire, busy;
  logic [7:0]  head, code;
  q_ctrl_t     q_ctrl;
  q_stat_t     q_stat;
  result_t     res, main_q, skid_q;
  logic        main_v_q, skid_v_q;

  assign dot_len = (dot_q == '0) ? 16'd1 : dot_q;
  assign len1    = {3'b000, dot_len};
  assign len3    = 19'(len1 << 1) + len1;
  assign len7    = 19'(len1 << 3) - len1;

  assign in_fire      = in_i.valid && in_i.ready;
  assign out_fire     = main_v_q && out_o.ready;
  assign in_i.ready   = !skid_v_q;
  assign cfg_i.ready  = 1'b1;

  assign q_ctrl.push = in_fire && in_i.char_valid;
  assign q_ctrl.pop  = in_fire && (phase_q == PH_IDLE) &&
                       ((q_stat.occ != '0) || q_stat.push_ok);

  mck_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (q_ctrl),
    .push_data_i (in_i.char_code),
    .stat_o      (q_stat),
    .head_o      (head)
  );

  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    pat_d   = pat_q;
    left_d  = left_q;
    tone_d  = tone_q;
    code    = '0;
    if (q_ctrl.pop) begin
      if ((head >= CHAR_A) && (head <= CHAR_Z)) begin
        code    = letter_code(5'(head - CHAR_A));
        pat_d   = code[3:0];
        left_d  = code[6:4];
        phase_d = PH_TONE;
        timer_d = code[0] ? len3 : len1;
      end else if (head == CHAR_SPACE) begin
        phase_d = PH_SPACE;
        timer_d = len7;
      end
    end
    busy = (phase_d != PH_IDLE);
    case (phase_d)
      PH_TONE: begin
        tone_d  = ~tone_d;
        timer_d = timer_d - 19'd1;
        if (timer_d == '0) begin
          phase_d = PH_GAP;
          timer_d = len1;
        end
      end
      PH_GAP: begin
        tone_d  = 1'b0;
        timer_d = timer_d - 19'd1;
        if (timer_d == '0) begin
          left_d = left_d - 3'd1;
          pat_d  = pat_d >> 1;
          if (left_d != '0) begin
            phase_d = PH_TONE;
            timer_d = pat_d[0] ? len3 : len1;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_SPACE: begin
        tone_d  = 1'b0;
        timer_d = timer_d - 19'd1;
        if (timer_d == '0) begin
          phase_d = PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.speaker       = tone_d;
    res.bar_levels[0] = q_stat.occ_next >= cnt_t'(1);
    res.bar_levels[1] = q_stat.occ_next >= cnt_t'(2);
    res.bar_levels[2] = q_stat.occ_next >= cnt_t'(3);
    res.bar_levels[3] = q_stat.occ_next >= cnt_t'(4);
    res.queue_count   = 8'(q_stat.occ_next);
    res.dropped       = q_ctrl.push && !q_stat.push_ok;
    res.busy_res      = busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      pat_q   <= '0;
      left_q  <= '0;
      tone_q  <= 1'b0;
      dot_q   <= DOT_RESET;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        timer_q <= timer_d;
        pat_q   <= pat_d;
        left_q  <= left_d;
        tone_q  <= tone_d;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        dot_q <= cfg_i.dot_ticks;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!main_v_q || out_fire) begin
      if (skid_v_q) begin
        main_v_q <= 1'b1;
        skid_v_q <= in_fire;
      end else begin
        main_v_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_v_q || out_fire) begin
      if (skid_v_q) begin
        main_q <= skid_q;
        if (in_fire) begin
          skid_q <= res;
        end
      end else if (in_fire) begin
        main_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_o.valid       = main_v_q;
  assign out_o.speaker     = main_q.speaker;
  assign out_o.bar_levels  = main_q.bar_levels;
  assign out_o.queue_count = main_q.queue_count;
  assign out_o.dropped     = main_q.dropped;
  assign out_o.busy_res    = main_q.busy_res;

`ifndef NO_ASSERTIONS
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry without main entry");

  a_idle_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (timer_q == '0))
    else $error("idle player with running timer");

  a_active_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (timer_q != '0))
    else $error("active phase with expired timer");

  a_bars_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_v_q && (main_q.queue_count >= 8'd4)) |-> (main_q.bar_levels == 4'hF))
    else $error("thermometer disagrees with queue count");
`endif
endmodule
